/* rtl/core/glmf_pkg.sv */
`timescale 1ns / 1ps

package glmf_pkg;

  // grid geometry and value format
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 4096;
  localparam int VALUE_BITS = 16;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);

  // configuration register widths and indexes
  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 11;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

  // reports per input and result queue
  localparam int REP_N    = 3;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // one accepted grid cell with its position flags
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] ncol;
    value_t           value;
    logic             last_row;
    logic             last_col;
  } item_t;

  // one peak report
  typedef struct packed {
    logic             vld;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } report_t;

endpackage

/* rtl/core/glmf_ram.sv */
`timescale 1ns / 1ps

module glmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/glmf_window.sv */
`timescale 1ns / 1ps

module glmf_window
  import glmf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc,
  input  item_t                   item,
  input  value_t                  prev_rdata,
  input  value_t                  older_rdata,
  output logic                    busy,
  output logic                    prev_we,
  output logic [COL_W-1:0]        prev_waddr,
  output value_t                  prev_wdata,
  output logic                    older_we,
  output logic [COL_W-1:0]        older_waddr,
  output value_t                  older_wdata,
  output report_t [REP_N-1:0]     reps
);

  logic   s1_vld_r;
  item_t  s1_r;
  logic   fwd_p_r, fwd_o_r, self_r;
  value_t fwdp_data_r, fwdo_data_r;
  value_t above_r, l0_r, l1_r, l2_r;

  value_t right, older;
  logic   pk_a, pk_b, pk_c;
  logic   row_ge1, row_ge2, col_ge1, col_ge2;

  // stage register: item waits here for the line store reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r        <= item;
      self_r      <= (item.ncol == item.col);
      fwd_p_r     <= s1_vld_r && (s1_r.col == item.ncol);
      fwd_o_r     <= s1_vld_r && (s1_r.col == item.col);
      fwdp_data_r <= s1_r.value;
      fwdo_data_r <= above_r;
    end
  end

  // neighbor registers, advanced as each item finishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r <= '0;
      l0_r    <= '0;
      l1_r    <= '0;
      l2_r    <= '0;
    end else if (s1_vld_r) begin
      above_r <= right;
      l0_r    <= above_r;
      l1_r    <= s1_r.value;
      l2_r    <= l1_r;
    end
  end

  // forwarding over writes landing in the same cycle as the read
  always_comb begin
    if (self_r) begin
      right = s1_r.value;
    end else if (fwd_p_r) begin
      right = fwdp_data_r;
    end else begin
      right = prev_rdata;
    end
    older = fwd_o_r ? fwdo_data_r : older_rdata;
  end

  assign row_ge1 = (s1_r.row != '0);
  assign row_ge2 = (s1_r.row > ROW_W'(1));
  assign col_ge1 = (s1_r.col != '0);
  assign col_ge2 = (s1_r.col > COL_W'(1));

  // peak decisions: row above here, last row one back, last cell of grid
  always_comb begin
    pk_a = s1_vld_r && row_ge1 && (above_r >= s1_r.value)
        && (!row_ge2 || (above_r >= older))
        && (!col_ge1 || (above_r >= l0_r))
        && (s1_r.last_col || (above_r >= right));
    pk_b = s1_vld_r && s1_r.last_row && col_ge1 && (l1_r >= s1_r.value)
        && (!col_ge2 || (l1_r >= l2_r))
        && (!row_ge1 || (l1_r >= l0_r));
    pk_c = s1_vld_r && s1_r.last_row && s1_r.last_col
        && (!col_ge1 || (s1_r.value >= l1_r))
        && (!row_ge1 || (s1_r.value >= above_r));
  end

  // report set in emission order
  always_comb begin
    reps[0].vld  = pk_a;
    reps[0].row  = s1_r.row - ROW_W'(1);
    reps[0].col  = s1_r.col;
    reps[0].last = !pk_b && !pk_c;
    reps[1].vld  = pk_b;
    reps[1].row  = s1_r.row;
    reps[1].col  = s1_r.col - COL_W'(1);
    reps[1].last = !pk_c;
    reps[2].vld  = pk_c;
    reps[2].row  = s1_r.row;
    reps[2].col  = s1_r.col;
    reps[2].last = 1'b1;
  end

  // line store write-back: shift the column down one line
  assign prev_we     = s1_vld_r;
  assign prev_waddr  = s1_r.col;
  assign prev_wdata  = s1_r.value;
  assign older_we    = s1_vld_r;
  assign older_waddr = s1_r.col;
  assign older_wdata = above_r;
  assign busy        = s1_vld_r;

endmodule

/* rtl/core/glmf_outq.sv */
`timescale 1ns / 1ps

module glmf_outq
  import glmf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  report_t [REP_N-1:0] reps,
  output logic                q_vld,
  input  logic                q_rdy,
  output report_t             q_head,
  output logic [OQ_CNT_W-1:0] q_cnt
);

  report_t               ent_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wptr_r, rptr_r;
  logic [OQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [OQ_PTR_W-1:0]   pos [REP_N];
  logic [OQ_PTR_W-1:0]   npush;
  logic                  pop;

  // compacted write positions for the valid reports
  always_comb begin
    npush = '0;
    for (int k = 0; k < REP_N; k++) begin
      pos[k] = wptr_r + npush;
      npush  = npush + OQ_PTR_W'(reps[k].vld);
    end
  end

  assign pop     = q_vld && q_rdy;
  assign cnt_nxt = cnt_r + OQ_CNT_W'(npush) - OQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < REP_N; k++) begin
      if (reps[k].vld) begin
        ent_r[pos[k]] <= reps[k];
      end
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + npush;
      rptr_r <= rptr_r + OQ_PTR_W'(pop);
      cnt_r  <= cnt_nxt;
    end
  end

  assign q_vld  = (cnt_r != '0);
  assign q_head = ent_r[rptr_r];
  assign q_cnt  = cnt_r;

endmodule

/* rtl/core/grid_local_maximum_finder_unit.sv */
`timescale 1ns / 1ps

// Four-neighbor local maximum finder. Grid values stream in raster order, one per
// cycle; every cell that is at least as large as each existing up, down, left and
// right neighbor is reported as (row, col), ties included, in row-major order and
// one row late, but bottom-row reports interleave with the row above. An input is
// taken every cycle while the result queue has room for the up to three reports a
// cell can cause; reports leave one per cycle, so the rate is one cell per cycle while
// at most two reports wait in the result queue and out_tready stays high. The two
// line stores need no clearing after reset. Writing grid_rows or grid_cols restarts
// the grid at row 0, column 0; write only while idle.

module grid_local_maximum_finder_unit
  import glmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] cell_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [11:0] peak_row, [21:12] peak_col, zero pad
  output logic                  out_tlast   // last_of_run
);

  logic [ROWS_CFG_W-1:0] rows_r, eff_rows;
  logic [COLS_CFG_W-1:0] cols_r, eff_cols;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic                  acc;
  item_t                 item;
  value_t                prev_rdata, older_rdata;
  logic                  busy;
  logic                  prev_we, older_we;
  logic [COL_W-1:0]      prev_waddr, older_waddr;
  value_t                prev_wdata, older_wdata;
  report_t [REP_N-1:0]   reps;
  report_t               head;
  logic [OQ_CNT_W-1:0]   q_cnt;
  logic [OQ_CNT_W+1:0]   fill;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_CFG_W'(1);
      cols_r <= COLS_CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GRID_ROWS: rows_r <= cfg_wdata[ROWS_CFG_W-1:0];
        REG_GRID_COLS: cols_r <= cfg_wdata[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry to the supported range
  always_comb begin
    if (rows_r == '0) begin
      eff_rows = ROWS_CFG_W'(1);
    end else if (rows_r > ROWS_CFG_W'(MAX_ROWS)) begin
      eff_rows = ROWS_CFG_W'(MAX_ROWS);
    end else begin
      eff_rows = rows_r;
    end
    if (cols_r == '0) begin
      eff_cols = COLS_CFG_W'(1);
    end else if (cols_r > COLS_CFG_W'(MAX_COLS)) begin
      eff_cols = COLS_CFG_W'(MAX_COLS);
    end else begin
      eff_cols = cols_r;
    end
  end

  // position of the incoming cell
  always_comb begin
    item.row      = row_r;
    item.col      = col_r;
    item.value    = value_t'(in_tdata[VALUE_BITS-1:0]);
    item.last_row = ((ROWS_CFG_W'(row_r) + ROWS_CFG_W'(1)) == eff_rows);
    item.last_col = ((COLS_CFG_W'(col_r) + COLS_CFG_W'(1)) == eff_cols);
    item.ncol     = item.last_col ? '0 : col_r + COL_W'(1);
    if (!item.last_col) begin
      row_nxt = row_r;
    end else if (item.last_row) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_r + ROW_W'(1);
    end
    col_nxt = item.ncol;
  end

  // accept only with room for every report still possibly in flight
  assign fill      = (OQ_CNT_W+2)'(q_cnt) + (busy ? (OQ_CNT_W+2)'(REP_N) : '0);
  assign in_tready = (fill <= (OQ_CNT_W+2)'(OQ_DEPTH - REP_N));
  assign acc       = in_tvalid && in_tready;

  // raster counters, restarted by any register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_we && (cfg_idx == REG_GRID_ROWS || cfg_idx == REG_GRID_COLS)) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // row above: read ahead at the next column
  glmf_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_COLS)
  ) u_prev_line (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (acc),
    .raddr (item.ncol),
    .rdata (prev_rdata)
  );

  // row two above: read at the current column
  glmf_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_COLS)
  ) u_older_line (
    .clk   (clk),
    .we    (older_we),
    .waddr (older_waddr),
    .wdata (older_wdata),
    .re    (acc),
    .raddr (item.col),
    .rdata (older_rdata)
  );

  glmf_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .item        (item),
    .prev_rdata  (prev_rdata),
    .older_rdata (older_rdata),
    .busy        (busy),
    .prev_we     (prev_we),
    .prev_waddr  (prev_waddr),
    .prev_wdata  (prev_wdata),
    .older_we    (older_we),
    .older_waddr (older_waddr),
    .older_wdata (older_wdata),
    .reps        (reps)
  );

  glmf_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .reps   (reps),
    .q_vld  (out_tvalid),
    .q_rdy  (out_tready),
    .q_head (head),
    .q_cnt  (q_cnt)
  );

  // result transaction
  assign out_tdata = {2'b00, head.col, head.row};
  assign out_tlast = head.last;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import glmf_pkg::*;

  // one peak report: grid position plus end-of-run marker
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } peak_rec_t;

  localparam int HOLD_CYCLES = 200;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 out_tlast;

  grid_local_maximum_finder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // stimulus and expectation stores
  logic [15:0] cell_feed[$];
  peak_rec_t   peak_expect[$];
  int          err_count = 0;
  int          random_cells = 0;

  // traffic shaping, set by the sequence
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_gen = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  bit          in_fire = 1'b0;

  // predictor state
  logic [ROWS_CFG_W-1:0] grid_rows_q = ROWS_CFG_W'(1);
  logic [COLS_CFG_W-1:0] grid_cols_q = COLS_CFG_W'(1);
  int                    row_pos = 0;
  int                    col_pos = 0;
  value_t                line_above[MAX_COLS];
  value_t                line_two_up[MAX_COLS];
  value_t                above_left = '0;
  value_t                cur_left1 = '0;
  value_t                cur_left2 = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // register write seen by the predictor: restarts the grid
  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] wdata);
    if (idx == REG_GRID_ROWS) begin
      grid_rows_q = wdata[ROWS_CFG_W-1:0];
    end else if (idx == REG_GRID_COLS) begin
      grid_cols_q = wdata[COLS_CFG_W-1:0];
    end
    row_pos = 0;
    col_pos = 0;
  endfunction

  // decide the cells that this value completes and queue their reports
  function automatic void predict_peaks(input logic [15:0] raw);
    int        rows;
    int        cols;
    int        r;
    int        c;
    int        n;
    bit        last_row;
    bit        peak;
    value_t    v;
    value_t    ctr;
    peak_rec_t found[3];
    rows = (grid_rows_q == 0) ? 1 :
           ((grid_rows_q > MAX_ROWS) ? MAX_ROWS : int'(grid_rows_q));
    cols = (grid_cols_q == 0) ? 1 :
           ((grid_cols_q > MAX_COLS) ? MAX_COLS : int'(grid_cols_q));
    r = row_pos;
    c = col_pos;
    v = value_t'(raw);
    n = 0;
    last_row = (r + 1 == rows);
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
      last_row = (rows == 1);
    end

    // cell of the row above at this column
    if (r >= 1) begin
      ctr = line_above[c];
      peak = (ctr >= v);
      if (r >= 2 && ctr < line_two_up[c]) peak = 1'b0;
      if (c >= 1 && ctr < above_left) peak = 1'b0;
      if (c + 1 < cols && ctr < line_above[c+1]) peak = 1'b0;
      if (peak) begin
        found[n].row = ROW_W'(r - 1);
        found[n].col = COL_W'(c);
        found[n].last = 1'b0;
        n++;
      end
    end

    // bottom-row cell one column back, now that its right neighbor is here
    if (last_row && c >= 1) begin
      ctr = cur_left1;
      peak = (ctr >= v);
      if (c >= 2 && ctr < cur_left2) peak = 1'b0;
      if (r >= 1 && ctr < line_two_up[c-1]) peak = 1'b0;
      if (peak) begin
        found[n].row = ROW_W'(r);
        found[n].col = COL_W'(c - 1);
        found[n].last = 1'b0;
        n++;
      end
    end

    // final cell of the grid is decided at once
    if (last_row && c + 1 == cols) begin
      peak = 1'b1;
      if (c >= 1 && v < cur_left1) peak = 1'b0;
      if (r >= 1 && v < line_above[c]) peak = 1'b0;
      if (peak) begin
        found[n].row = ROW_W'(r);
        found[n].col = COL_W'(c);
        found[n].last = 1'b0;
        n++;
      end
    end

    if (n > 0) found[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) peak_expect.push_back(found[i]);

    // shift line stores and neighbor registers
    above_left = line_above[c];
    line_two_up[c] = line_above[c];
    line_above[c] = v;
    cur_left2 = cur_left1;
    cur_left1 = v;

    if (c + 1 < cols) begin
      col_pos = c + 1;
      row_pos = r;
    end else begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end
  endfunction

  // cell driver: holds an offered value until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;
    end else if (cell_feed.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      in_tvalid <= 1'b1;
      in_tdata <= cell_feed.pop_front();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // report sink: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: predict on accepted cells, check every report transaction
  always @(posedge clk) begin
    peak_rec_t want;
    in_fire = in_tvalid && in_tready && rst_n;
    if (rst_n) begin
      if (cfg_we) apply_cfg(cfg_idx, cfg_wdata);
      if (in_fire) predict_peaks(in_tdata);
      if (out_tvalid && out_tready) begin
        if (peak_expect.size() == 0) begin
          $display("%0t unexpected report: expected none, got row %0d col %0d last %0d",
                   $time, out_tdata[ROW_W-1:0], out_tdata[ROW_W+COL_W-1:ROW_W], out_tlast);
          err_count++;
        end else begin
          want = peak_expect.pop_front();
          if (out_tdata[ROW_W-1:0] !== want.row ||
              out_tdata[ROW_W+COL_W-1:ROW_W] !== want.col ||
              out_tlast !== want.last) begin
            $display({"%0t report mismatch: expected row %0d col %0d last %0d,",
                      " got row %0d col %0d last %0d"},
                     $time, want.row, want.col, want.last, out_tdata[ROW_W-1:0],
                     out_tdata[ROW_W+COL_W-1:ROW_W], out_tlast);
            err_count++;
          end
        end
      end
    end
  end

  // wait until every cell is taken and every report has left, then drain
  task automatic wait_idle();
    do @(posedge clk);
    while (cell_feed.size() != 0 || in_tvalid || peak_expect.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic start_grid(input int rows, input int cols);
    wait_idle();
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_GRID_COLS, cols);
  endtask

  // random cell values: narrow range for ties, full range, or extremes
  task automatic queue_cells(input int count, input int style);
    int pick;
    logic [15:0] val;
    for (int i = 0; i < count; i++) begin
      if (style == 0) begin
        pick = $urandom_range(0, 6) - 3;
        val = pick[15:0];
      end else if (style == 1) begin
        val = 16'($urandom());
      end else begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: val = 16'h8000;
          1: val = 16'h7FFF;
          2: val = 16'h0000;
          3: val = 16'hFFFF;
          default: val = 16'($urandom());
        endcase
      end
      cell_feed.push_back(val);
    end
  endtask

  initial begin
    int frame;
    int rows;
    int cols;
    int count;
    int sel;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry is a single cell: always a peak
    cell_feed.push_back(16'h7FFF);
    cell_feed.push_back(16'h8000);
    cell_feed.push_back(16'h0000);

    // zero registers behave as one row, one column
    start_grid(0, 0);
    cell_feed.push_back(16'h1234);

    // all-equal grid: every cell ties
    start_grid(2, 2);
    repeat (4) cell_feed.push_back(16'h0005);

    // extremes on corners, edges and center
    start_grid(3, 3);
    cell_feed.push_back(16'h0000);
    cell_feed.push_back(16'h7FFF);
    cell_feed.push_back(16'h0000);
    cell_feed.push_back(16'h8000);
    cell_feed.push_back(16'h7FFF);
    cell_feed.push_back(16'h8000);
    cell_feed.push_back(16'h0001);
    cell_feed.push_back(16'h0001);
    cell_feed.push_back(16'hFFFF);

    // oversized rows, single column
    start_grid(13'h1FFF, 1);
    cell_feed.push_back(16'h0003);
    cell_feed.push_back(16'h0003);
    cell_feed.push_back(16'hFFFE);
    cell_feed.push_back(16'h7FFF);

    // oversized columns, single row
    start_grid(1, 13'h1FFF);
    cell_feed.push_back(16'h8000);
    cell_feed.push_back(16'h7FFF);
    cell_feed.push_back(16'h7FFF);
    cell_feed.push_back(16'h0000);
    cell_feed.push_back(16'h4000);

    // long receiver hold-off on a grid full of peaks
    start_grid(4, 6);
    hold_gen = hold_gen + 1;
    repeat (24) cell_feed.push_back(16'h0007);

    // random grids across the traffic phases
    frame = 0;
    while (random_cells < 170) begin
      sel = frame % 4;
      rows = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 6);
      cols = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 8);
      count = rows * cols;
      case ($urandom_range(0, 9))
        0: count = $urandom_range(1, count);
        1: count = count + $urandom_range(1, 3);
        default: ;
      endcase
      start_grid(rows, cols);
      case (sel)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      queue_cells(count, $urandom_range(0, 2));
      random_cells = random_cells + count;
      frame++;
    end

    wait_idle();
    if (err_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/glmf_pkg.sv
rtl/core/glmf_ram.sv
rtl/core/glmf_window.sv
rtl/core/glmf_outq.sv
rtl/core/grid_local_maximum_finder_unit.sv
sim/tb.sv
